// File: src/budgeted_task_dispatcher_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the dispatcher RTL.
// ---------------------------------------------------------------------------
`ifndef BUDGETED_TASK_DISPATCHER_DEFINES_SVH
`define BUDGETED_TASK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("budgeted_task_dispatcher check failed");

// Next-cycle implication, disabled while reset is held.
`define BTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("budgeted_task_dispatcher check failed");

`endif

// File: src/btd_pkg.sv
// ---------------------------------------------------------------------------
// btd_pkg
// Command, event and register codes and the slot entry type.
// ---------------------------------------------------------------------------
`default_nettype none

package btd_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam logic [1:0] EV_DISPATCH    = 2'd0;
    localparam logic [1:0] EV_DONE        = 2'd1;
    localparam logic [1:0] EV_NO_INSTANCE = 2'd2;

    localparam logic [1:0] CFG_CPU_BUDGET = 2'd0;
    localparam logic [1:0] CFG_MEM_BUDGET = 2'd1;
    localparam logic [1:0] CFG_THREAD_LIM = 2'd2;
    localparam logic [1:0] CFG_RUN_TICKS  = 2'd3;

    // Per-slot costs and period, kept in the slot store.
    typedef struct packed {
        logic [15:0] cpu;
        logic [15:0] mem;
        logic [15:0] period;
    } t_slot_entry;

endpackage

`default_nettype wire

// File: src/btd_slot_store.sv
// ---------------------------------------------------------------------------
// btd_slot_store
// Slot cost memory and next-eligible time memory, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module btd_slot_store
    import btd_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int IW = $clog2(SLOTS)
) (
    input  wire                 i_clk,
    input  wire                 i_par_we,
    input  wire  [IW-1:0]       i_par_addr,
    input  wire  t_slot_entry   i_par_data,
    input  wire                 i_ne_we,
    input  wire  [IW-1:0]       i_ne_addr,
    input  wire  [31:0]         i_ne_data,
    input  wire  [IW-1:0]       i_rd_addr,
    output t_slot_entry         o_rd_par,
    output logic [31:0]         o_rd_ne
);

    t_slot_entry par_mem [SLOTS];
    logic [31:0] ne_mem  [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_par_we) begin
            par_mem[i_par_addr] <= i_par_data;
        end
        if (i_ne_we) begin
            ne_mem[i_ne_addr] <= i_ne_data;
        end
        o_rd_par <= par_mem[i_rd_addr];
        o_rd_ne  <= ne_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: src/budgeted_task_dispatcher.sv
// ---------------------------------------------------------------------------
// budgeted_task_dispatcher
// Admission scheduler: dispatches loaded slots against cpu, memory and
// thread budgets, one slot per cycle through a shared fit/charge unit.
// Input beats (i_valid/o_stall) carry load, start, tick and finish commands;
// one command is taken at a time and o_stall stays high until its last
// result beat is in the output register. Result beats (o_valid/i_stall)
// leave from that register; o_last marks the closing beat of a command.
// Configuration (i_cfg_valid/o_cfg_ready) is always ready; write it idle.
// Load, start and a tick at or past the run limit go to ST_DONE, finish to
// ST_FIN; that state puts the single beat in the output register once it is
// free and returns to idle, where the next command is taken.
// A tick before the limit scans every slot twice (one-shots, then daemons)
// at one slot per cycle, unless held by a stall, through a read-ahead slot
// memory, then goes to ST_DONE for its closing beat; the next command is
// taken once the block is back in idle.
// Receiver stall holds the scan on the slot that wants to dispatch.
// Reset (synchronous, active low) clears budgets, totals, slot valid,
// pending and instance counts; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "budgeted_task_dispatcher_defines.svh"

module budgeted_task_dispatcher
    import btd_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int POOL_MAX = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_cmd,
    input  wire  [3:0]  i_slot,
    input  wire         i_is_daemon,
    input  wire  [15:0] i_cpu_cost,
    input  wire  [15:0] i_mem_cost,
    input  wire  [15:0] i_period_ticks,
    // result channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_event_res,
    output logic [3:0]  o_slot_out,
    output logic [18:0] o_cpu_in_use,
    output logic [18:0] o_memory_in_use,
    output logic [3:0]  o_running_now,
    output logic        o_run_over,
    output logic        o_last,
    // configuration channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    localparam int         IW       = $clog2(SLOTS);
    localparam logic [3:0] POOL_LIM = 4'(POOL_MAX);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_DONE
    } t_state;

    // control state
    t_state             r_state,  n_state;
    logic [19:0]        r_cpu_budget, n_cpu_budget;
    logic [19:0]        r_mem_budget, n_mem_budget;
    logic [3:0]         r_thread_lim, n_thread_lim;
    logic [31:0]        r_run_ticks,  n_run_ticks;
    logic [SLOTS-1:0]   r_valid,   n_valid;
    logic [SLOTS-1:0]   r_pending, n_pending;
    logic [SLOTS-1:0]   r_ne_set,  n_ne_set;
    logic [3:0]         r_inst_cnt [SLOTS];
    logic [3:0]         n_inst_cnt [SLOTS];
    logic [19:0]        r_used_cpu, n_used_cpu;
    logic [19:0]        r_used_mem, n_used_mem;
    logic [3:0]         r_running_total, n_running_total;
    logic [31:0]        r_tick, n_tick;
    logic [IW-1:0]      r_idx, n_idx;
    logic               r_pass, n_pass;
    logic               r_out_valid, n_out_valid;

    // payload
    logic [SLOTS-1:0]   r_daemon, n_daemon;
    logic [3:0]         r_slot, n_slot;
    logic [3:0]         r_done_slot, n_done_slot;
    logic [1:0]         r_out_event, n_out_event;
    logic [3:0]         r_out_slot, n_out_slot;
    logic [18:0]        r_out_cpu, n_out_cpu;
    logic [18:0]        r_out_mem, n_out_mem;
    logic [3:0]         r_out_running, n_out_running;
    logic               r_out_over, n_out_over;
    logic               r_out_last, n_out_last;

    // slot store
    logic               par_we;
    t_slot_entry        par_data;
    logic               ne_we;
    logic [31:0]        ne_data;
    logic [IW-1:0]      rd_addr;
    t_slot_entry        rd_par;
    logic [31:0]        rd_ne;

    btd_slot_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_par_we   (par_we),
        .i_par_addr (IW'(i_slot)),
        .i_par_data (par_data),
        .i_ne_we    (ne_we),
        .i_ne_addr  (r_idx),
        .i_ne_data  (ne_data),
        .i_rd_addr  (rd_addr),
        .o_rd_par   (rd_par),
        .o_rd_ne    (rd_ne)
    );

    // shared fit / charge unit, fed from the registered read data
    logic [3:0]   thr_lim;
    logic [20:0]  sum_cpu, sum_mem;
    logic         fits;
    logic [31:0]  ne_eff;
    logic [32:0]  next_time;
    logic         cand, disp, can_emit;
    logic         in_ok, fin_ok;
    logic [IW-1:0] in_idx, fin_idx;
    logic         e_load;
    logic [1:0]   e_event;
    logic [3:0]   e_slot;
    logic         e_last;

    assign thr_lim   = (r_thread_lim < POOL_LIM) ? r_thread_lim : POOL_LIM;
    assign sum_cpu   = {1'b0, r_used_cpu} + 21'(rd_par.cpu);
    assign sum_mem   = {1'b0, r_used_mem} + 21'(rd_par.mem);
    assign fits      = (r_running_total < thr_lim) &&
                       (sum_cpu <= {1'b0, r_cpu_budget}) &&
                       (sum_mem <= {1'b0, r_mem_budget});
    assign ne_eff    = r_ne_set[r_idx] ? rd_ne : 32'd0;
    assign next_time = {1'b0, r_tick} + 33'(rd_par.period);
    assign cand      = r_pass ?
                       (r_valid[r_idx] && r_daemon[r_idx] && (r_tick >= ne_eff)) :
                       (r_valid[r_idx] && !r_daemon[r_idx] && r_pending[r_idx]);
    assign disp      = cand && fits;
    assign can_emit  = !r_out_valid || !i_stall;

    assign in_idx    = IW'(i_slot);
    assign in_ok     = ({28'd0, i_slot} < 32'(SLOTS));
    assign fin_idx   = IW'(r_slot);
    assign fin_ok    = ({28'd0, r_slot} < 32'(SLOTS)) && (r_inst_cnt[fin_idx] != 4'd0);

    assign par_data.cpu    = i_cpu_cost;
    assign par_data.mem    = i_mem_cost;
    assign par_data.period = i_period_ticks;
    assign ne_data         = next_time[32] ? 32'hFFFF_FFFF : next_time[31:0];

    always_comb begin
        n_state         = r_state;
        n_cpu_budget    = r_cpu_budget;
        n_mem_budget    = r_mem_budget;
        n_thread_lim    = r_thread_lim;
        n_run_ticks     = r_run_ticks;
        n_valid         = r_valid;
        n_pending       = r_pending;
        n_ne_set        = r_ne_set;
        n_inst_cnt      = r_inst_cnt;
        n_used_cpu      = r_used_cpu;
        n_used_mem      = r_used_mem;
        n_running_total = r_running_total;
        n_tick          = r_tick;
        n_idx           = r_idx;
        n_pass          = r_pass;
        n_daemon        = r_daemon;
        n_slot          = r_slot;
        n_done_slot     = r_done_slot;
        par_we          = 1'b0;
        ne_we           = 1'b0;
        rd_addr         = '0;
        e_load          = 1'b0;
        e_event         = EV_DONE;
        e_slot          = r_done_slot;
        e_last          = 1'b1;

        // register writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CPU_BUDGET: n_cpu_budget = i_cfg_data[19:0];
                CFG_MEM_BUDGET: n_mem_budget = i_cfg_data[19:0];
                CFG_THREAD_LIM: n_thread_lim = i_cfg_data[3:0];
                CFG_RUN_TICKS:  n_run_ticks  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd == CMD_FINISH) begin
                    rd_addr = in_idx;
                end
                if (i_valid) begin
                    n_done_slot = 4'd0;
                    case (i_cmd)
                        CMD_LOAD: begin
                            // a busy slot keeps its costs so finish returns them
                            if (in_ok && (r_inst_cnt[in_idx] == 4'd0)) begin
                                par_we           = 1'b1;
                                n_valid[in_idx]  = 1'b1;
                                n_daemon[in_idx] = i_is_daemon;
                            end
                            n_done_slot = i_slot;
                            n_state     = ST_DONE;
                        end
                        CMD_START: begin
                            n_tick    = 32'd0;
                            n_pending = r_valid & ~r_daemon;
                            n_ne_set  = '0;
                            n_state   = ST_DONE;
                        end
                        CMD_TICK: begin
                            if (r_tick < r_run_ticks) begin
                                n_idx   = '0;
                                n_pass  = 1'b0;
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        CMD_FINISH: begin
                            n_slot  = i_slot;
                            n_state = ST_FIN;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end

            ST_SCAN: begin
                if (disp && !can_emit) begin
                    // hold this slot until the result register frees
                    rd_addr = r_idx;
                end else begin
                    if (disp) begin
                        n_used_cpu        = sum_cpu[19:0];
                        n_used_mem        = sum_mem[19:0];
                        n_running_total   = r_running_total + 4'd1;
                        n_inst_cnt[r_idx] = r_inst_cnt[r_idx] + 4'd1;
                        if (r_pass) begin
                            ne_we           = 1'b1;
                            n_ne_set[r_idx] = 1'b1;
                        end else begin
                            n_pending[r_idx] = 1'b0;
                        end
                        e_load  = 1'b1;
                        e_event = EV_DISPATCH;
                        e_slot  = 4'(r_idx);
                        e_last  = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        if (!r_pass) begin
                            n_pass  = 1'b1;
                            n_idx   = '0;
                            rd_addr = '0;
                        end else begin
                            n_tick  = r_tick + 32'd1;
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        rd_addr = r_idx + IW'(1);
                    end
                end
            end

            ST_FIN: begin
                // keep the finished slot's costs on the read port while stalled
                rd_addr = fin_idx;
                if (can_emit) begin
                    e_load = 1'b1;
                    e_slot = r_slot;
                    if (fin_ok) begin
                        n_inst_cnt[fin_idx] = r_inst_cnt[fin_idx] - 4'd1;
                        n_used_cpu = (r_used_cpu >= 20'(rd_par.cpu)) ?
                                     r_used_cpu - 20'(rd_par.cpu) : 20'd0;
                        n_used_mem = (r_used_mem >= 20'(rd_par.mem)) ?
                                     r_used_mem - 20'(rd_par.mem) : 20'd0;
                        if (r_running_total != 4'd0) begin
                            n_running_total = r_running_total - 4'd1;
                        end
                    end else begin
                        e_event = EV_NO_INSTANCE;
                    end
                    n_state = ST_IDLE;
                end
            end

            ST_DONE: begin
                if (can_emit) begin
                    e_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        // result register: load a new beat or drop the one taken
        n_out_event   = r_out_event;
        n_out_slot    = r_out_slot;
        n_out_cpu     = r_out_cpu;
        n_out_mem     = r_out_mem;
        n_out_running = r_out_running;
        n_out_over    = r_out_over;
        n_out_last    = r_out_last;
        n_out_valid   = r_out_valid && i_stall;
        if (e_load) begin
            n_out_valid   = 1'b1;
            n_out_event   = e_event;
            n_out_slot    = e_slot;
            n_out_cpu     = n_used_cpu[18:0];
            n_out_mem     = n_used_mem[18:0];
            n_out_running = n_running_total;
            n_out_over    = (r_tick >= r_run_ticks);
            n_out_last    = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_cpu_budget    <= '0;
            r_mem_budget    <= '0;
            r_thread_lim    <= '0;
            r_run_ticks     <= '0;
            r_valid         <= '0;
            r_pending       <= '0;
            r_ne_set        <= '0;
            r_inst_cnt      <= '{default: '0};
            r_used_cpu      <= '0;
            r_used_mem      <= '0;
            r_running_total <= '0;
            r_tick          <= '0;
            r_idx           <= '0;
            r_pass          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_cpu_budget    <= n_cpu_budget;
            r_mem_budget    <= n_mem_budget;
            r_thread_lim    <= n_thread_lim;
            r_run_ticks     <= n_run_ticks;
            r_valid         <= n_valid;
            r_pending       <= n_pending;
            r_ne_set        <= n_ne_set;
            r_inst_cnt      <= n_inst_cnt;
            r_used_cpu      <= n_used_cpu;
            r_used_mem      <= n_used_mem;
            r_running_total <= n_running_total;
            r_tick          <= n_tick;
            r_idx           <= n_idx;
            r_pass          <= n_pass;
            r_out_valid     <= n_out_valid;
        end
        r_daemon      <= n_daemon;
        r_slot        <= n_slot;
        r_done_slot   <= n_done_slot;
        r_out_event   <= n_out_event;
        r_out_slot    <= n_out_slot;
        r_out_cpu     <= n_out_cpu;
        r_out_mem     <= n_out_mem;
        r_out_running <= n_out_running;
        r_out_over    <= n_out_over;
        r_out_last    <= n_out_last;
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_event_res     = r_out_event;
    assign o_slot_out      = r_out_slot;
    assign o_cpu_in_use    = r_out_cpu;
    assign o_memory_in_use = r_out_mem;
    assign o_running_now   = r_out_running;
    assign o_run_over      = r_out_over;
    assign o_last          = r_out_last;

    // never more instances than the pool allows
    `BTD_ASSERT_IMP(a_pool_bound, i_clk, i_rst_n, 1'b1, r_running_total <= POOL_LIM)
    // an accepted command always makes the block busy, raising o_stall
    `BTD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // a dispatch beat reports the instance it just charged
    `BTD_ASSERT_IMP(a_dispatch_running, i_clk, i_rst_n, o_valid && (o_event_res == EV_DISPATCH), (o_running_now != 4'd0) && !o_last)

endmodule

`default_nettype wire

// File: bench/tb_dispatch_pkg.sv
// ---------------------------------------------------------------------------
// Dispatcher scoreboard
// Beat types for the command and result channels, and a tracker that keeps
// its own copy of the dispatcher state, predicts the result beats of each
// accepted command and checks the beats that come back in order.
// ---------------------------------------------------------------------------
package tb_dispatch_pkg;

    import btd_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int POOL_LIMIT = 8;

    typedef struct packed {
        bit [1:0]  cmd;
        bit [3:0]  slot;
        bit        is_daemon;
        bit [15:0] cpu_cost;
        bit [15:0] mem_cost;
        bit [15:0] period_ticks;
    } t_cmd_beat;

    typedef struct packed {
        logic [1:0]  ev_code;
        logic [3:0]  slot_id;
        logic [18:0] cpu_use;
        logic [18:0] mem_use;
        logic [3:0]  running;
        logic        over;
        logic        last;
    } t_event_beat;

    class dispatch_tracker;

        bit [19:0] cpu_budget;
        bit [19:0] mem_budget;
        bit [3:0]  thread_limit;
        bit [31:0] run_ticks;

        bit        slot_valid[SLOT_COUNT];
        bit        slot_daemon[SLOT_COUNT];
        bit [15:0] slot_cpu[SLOT_COUNT];
        bit [15:0] slot_mem[SLOT_COUNT];
        bit [15:0] slot_period[SLOT_COUNT];
        bit        oneshot_pending[SLOT_COUNT];
        bit [31:0] next_time[SLOT_COUNT];
        bit [3:0]  instance_count[SLOT_COUNT];

        bit [19:0] used_cpu;
        bit [19:0] used_mem;
        bit [3:0]  running_total;
        bit [31:0] tick_time;

        t_event_beat expected_events[$];
        int          mismatches;

        function new();
            cpu_budget    = '0;
            mem_budget    = '0;
            thread_limit  = '0;
            run_ticks     = '0;
            used_cpu      = '0;
            used_mem      = '0;
            running_total = '0;
            tick_time     = '0;
            mismatches    = 0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_valid[i]      = 1'b0;
                slot_daemon[i]     = 1'b0;
                slot_cpu[i]        = '0;
                slot_mem[i]        = '0;
                slot_period[i]     = '0;
                oneshot_pending[i] = 1'b0;
                next_time[i]       = '0;
                instance_count[i]  = '0;
            end
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] data);
            case (idx)
                CFG_CPU_BUDGET: cpu_budget   = data[19:0];
                CFG_MEM_BUDGET: mem_budget   = data[19:0];
                CFG_THREAD_LIM: thread_limit = data[3:0];
                CFG_RUN_TICKS:  run_ticks    = data;
                default: ;
            endcase
        endfunction

        function void emit(bit [1:0] ev, bit [3:0] slot, bit last);
            t_event_beat e;
            e.ev_code = ev;
            e.slot_id = slot;
            e.cpu_use = used_cpu[18:0];
            e.mem_use = used_mem[18:0];
            e.running = running_total;
            e.over    = (tick_time >= run_ticks);
            e.last    = last;
            expected_events.insert(expected_events.size(), e);
        endfunction

        function bit fits(int s);
            bit [3:0] lim;
            lim = (thread_limit < POOL_LIMIT) ? thread_limit : 4'(POOL_LIMIT);
            return (running_total < lim) &&
                   ({1'b0, used_cpu} + 21'(slot_cpu[s]) <= {1'b0, cpu_budget}) &&
                   ({1'b0, used_mem} + 21'(slot_mem[s]) <= {1'b0, mem_budget});
        endfunction

        function void charge(int s);
            used_cpu          = used_cpu + 20'(slot_cpu[s]);
            used_mem          = used_mem + 20'(slot_mem[s]);
            running_total     = running_total + 4'd1;
            instance_count[s] = instance_count[s] + 4'd1;
        endfunction

        // Predict every result beat of one accepted command.
        function void note_command(t_cmd_beat b);
            bit [32:0] nt;
            int        s;
            s = int'(b.slot);
            case (b.cmd)
                CMD_LOAD: begin
                    // a slot with running instances keeps its costs
                    if (instance_count[s] == 0) begin
                        slot_valid[s]  = 1'b1;
                        slot_daemon[s] = b.is_daemon;
                        slot_cpu[s]    = b.cpu_cost;
                        slot_mem[s]    = b.mem_cost;
                        slot_period[s] = b.period_ticks;
                    end
                    emit(EV_DONE, b.slot, 1'b1);
                end
                CMD_START: begin
                    tick_time = '0;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        oneshot_pending[i] = slot_valid[i] && !slot_daemon[i];
                        next_time[i]       = '0;
                    end
                    emit(EV_DONE, 4'd0, 1'b1);
                end
                CMD_FINISH: begin
                    if (instance_count[s] != 0) begin
                        instance_count[s] = instance_count[s] - 4'd1;
                        used_cpu = (used_cpu >= 20'(slot_cpu[s])) ?
                                   used_cpu - 20'(slot_cpu[s]) : '0;
                        used_mem = (used_mem >= 20'(slot_mem[s])) ?
                                   used_mem - 20'(slot_mem[s]) : '0;
                        if (running_total != 0) running_total = running_total - 4'd1;
                        emit(EV_DONE, b.slot, 1'b1);
                    end else begin
                        emit(EV_NO_INSTANCE, b.slot, 1'b1);
                    end
                end
                default: begin
                    if (tick_time < run_ticks) begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (slot_valid[i] && !slot_daemon[i] && oneshot_pending[i] &&
                                fits(i)) begin
                                charge(i);
                                oneshot_pending[i] = 1'b0;
                                emit(EV_DISPATCH, 4'(i), 1'b0);
                            end
                        end
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (slot_valid[i] && slot_daemon[i] &&
                                tick_time >= next_time[i] && fits(i)) begin
                                nt = {1'b0, tick_time} + 33'(slot_period[i]);
                                charge(i);
                                next_time[i] = nt[32] ? 32'hFFFF_FFFF : nt[31:0];
                                emit(EV_DISPATCH, 4'(i), 1'b0);
                            end
                        end
                        tick_time = tick_time + 32'd1;
                    end
                    emit(EV_DONE, 4'd0, 1'b1);
                end
            endcase
        endfunction

        function void match_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted result beat with the oldest prediction.
        function void check_event(t_event_beat got);
            t_event_beat want;
            if (expected_events.size() == 0) begin
                $error("result beat with nothing expected: event %0d slot %0d",
                       got.ev_code, got.slot_id);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            match_field("event_res", 32'(want.ev_code), 32'(got.ev_code));
            match_field("slot_out", 32'(want.slot_id), 32'(got.slot_id));
            match_field("cpu_in_use", 32'(want.cpu_use), 32'(got.cpu_use));
            match_field("memory_in_use", 32'(want.mem_use), 32'(got.mem_use));
            match_field("running_now", 32'(want.running), 32'(got.running));
            match_field("run_over", 32'(want.over), 32'(got.over));
            match_field("last", 32'(want.last), 32'(got.last));
        endfunction

    endclass

endpackage

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// Budgeted task dispatcher testbench
// Drives load, start, tick and finish commands into the dispatcher through
// the valid/stall command channel, with random gaps on the sender and
// random stall on the result side. A scoreboard predicts every result beat
// from its own copy of slot, budget and time state and checks the beats in
// order. A short directed part covers the corner cases, then random phases,
// each under a fresh budget setting written while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;

    import btd_pkg::*;
    import tb_dispatch_pkg::*;

    // A tick scans every slot twice, plus stalls; settle well past a tick.
    localparam int SETTLE_CYCLES = 48;
    // Slowest run: ~130 commands, up to 9 result beats each, every beat
    // waiting out the longest stall, plus sender gaps and settles.
    // Take several times that.
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS = 21;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [3:0]  i_slot;
    logic        i_is_daemon;
    logic [15:0] i_cpu_cost;
    logic [15:0] i_mem_cost;
    logic [15:0] i_period_ticks;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_event_res;
    logic [3:0]  o_slot_out;
    logic [18:0] o_cpu_in_use;
    logic [18:0] o_memory_in_use;
    logic [3:0]  o_running_now;
    logic        o_run_over;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    dispatch_tracker tracker;
    bit              quiet = 1'b0;   // phase with no gaps and no stall
    int              stall_left = 0;
    int              cycle_count = 0;

    budgeted_task_dispatcher DUT (.*);

    always #4 i_clk = ~i_clk;

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Cost mix: the extremes, small costs that pack well, and full range.
    function automatic bit [15:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'hFFFF;
        if (r < 60) return 16'($urandom_range(0, 4095));
        return 16'($urandom);
    endfunction

    function automatic bit [19:0] pick_budget();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 20'd0;
        if (r < 35) return 20'hFFFFF;
        if (r < 75) return 20'($urandom_range(0, 300000));
        return 20'($urandom);
    endfunction

    function automatic t_cmd_beat load_beat(bit [3:0] slot, bit daemon, bit [15:0] cpu,
                                            bit [15:0] mem, bit [15:0] period);
        t_cmd_beat b;
        b.cmd          = CMD_LOAD;
        b.slot         = slot;
        b.is_daemon    = daemon;
        b.cpu_cost     = cpu;
        b.mem_cost     = mem;
        b.period_ticks = period;
        return b;
    endfunction

    // Non-load command; the load fields carry noise the block must ignore.
    function automatic t_cmd_beat plain_beat(bit [1:0] cmd, bit [3:0] slot);
        t_cmd_beat b;
        b.cmd          = cmd;
        b.slot         = slot;
        b.is_daemon    = 1'($urandom);
        b.cpu_cost     = 16'($urandom);
        b.mem_cost     = 16'($urandom);
        b.period_ticks = 16'($urandom);
        return b;
    endfunction

    function automatic t_cmd_beat random_load();
        int        r;
        bit [15:0] period;
        r = $urandom_range(0, 99);
        // short periods keep daemons coming back within a phase
        period = (r < 30) ? 16'd0 : (r < 80) ? 16'($urandom_range(1, 4)) : 16'($urandom);
        return load_beat(4'($urandom), 1'($urandom), pick_cost(), pick_cost(), period);
    endfunction

    // Present one command beat after a random gap and hold it until accepted.
    // Valid stays high on return so back-to-back beats never drop it.
    task automatic send_cmd(input t_cmd_beat b);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= b.cmd;
        i_slot         <= b.slot;
        i_is_daemon    <= b.is_daemon;
        i_cpu_cost     <= b.cpu_cost;
        i_mem_cost     <= b.mem_cost;
        i_period_ticks <= b.period_ticks;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_command(b);
    endtask

    // Drop valid, wait for every predicted beat, then let the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bit [1:0] idx, input bit [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // Write all four registers back to back; call only with the block idle.
    task automatic configure(input bit [19:0] cpu, input bit [19:0] mem,
                             input bit [3:0] threads, input bit [31:0] run);
        write_reg(CFG_CPU_BUDGET, 32'(cpu));
        write_reg(CFG_MEM_BUDGET, 32'(mem));
        write_reg(CFG_THREAD_LIM, 32'(threads));
        write_reg(CFG_RUN_TICKS, run);
        i_cfg_valid <= 1'b0;
    endtask

    // A random phase opens with a well-formed prefix (a few loads, then a
    // start) so ticks have something to dispatch, then mixes commands with
    // finishes aimed mostly at slots that really have running instances.
    task automatic random_phase(input int n);
        int left;
        int r;
        bit [3:0] s;
        left = n;
        repeat ($urandom_range(3, 7)) begin
            send_cmd(random_load());
            left--;
        end
        send_cmd(plain_beat(CMD_START, 4'($urandom)));
        left--;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_cmd(random_load());
            end else if (r < 22) begin
                send_cmd(plain_beat(CMD_START, 4'($urandom)));
            end else if (r < 62) begin
                send_cmd(plain_beat(CMD_TICK, 4'($urandom)));
            end else if (r < 97) begin
                s = 4'($urandom);
                if (tracker.running_total != 0 && $urandom_range(0, 4) != 0) begin
                    while (tracker.instance_count[s] == 0) s = s + 4'd1;
                end
                send_cmd(plain_beat(CMD_FINISH, s));
            end else begin
                // hold off until the block has answered everything
                drain();
            end
            left--;
        end
    endtask

    // Receiver stall: free most cycles, now and then a stall run of random length.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // Sample result beats on the edge that moves them; values seen here are
    // the ones from before the edge, so the order of processes cannot matter.
    always @(posedge i_clk) begin : result_monitor
        t_event_beat got;
        got.ev_code = o_event_res;
        got.slot_id = o_slot_out;
        got.cpu_use = o_cpu_in_use;
        got.mem_use = o_memory_in_use;
        got.running = o_running_now;
        got.over    = o_run_over;
        got.last    = o_last;
        if (i_rst_n && o_valid && !i_stall) tracker.check_event(got);
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int        r;
        bit [3:0]  threads;
        bit [31:0] run;
        tracker = new();
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_LOAD;
        i_slot         <= '0;
        i_is_daemon    <= 1'b0;
        i_cpu_cost     <= '0;
        i_mem_cost     <= '0;
        i_period_ticks <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_CPU_BUDGET;
        i_cfg_data     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Widest budgets, full pool, three ticks of run time.
        configure(20'hFFFFF, 20'hFFFFF, 4'd8, 32'd3);
        // tick with nothing loaded, finish of a slot never loaded
        send_cmd(plain_beat(CMD_TICK, 4'd0));
        send_cmd(plain_beat(CMD_FINISH, 4'd5));
        send_cmd(load_beat(4'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_cmd(load_beat(4'd15, 1'b1, 16'd0, 16'd0, 16'd0));
        send_cmd(load_beat(4'd7, 1'b1, 16'hFFFF, 16'd1, 16'd1));
        send_cmd(load_beat(4'd3, 1'b0, 16'd1, 16'hFFFF, 16'd0));
        send_cmd(plain_beat(CMD_START, 4'd9));
        send_cmd(plain_beat(CMD_TICK, 4'd2));
        send_cmd(plain_beat(CMD_TICK, 4'd4));
        // reload of a slot with running instances must be ignored
        send_cmd(load_beat(4'd15, 1'b0, 16'hFFFF, 16'hFFFF, 16'd7));
        // this tick fills the pool to its limit
        send_cmd(plain_beat(CMD_TICK, 4'd6));
        // run limit reached: nothing dispatched, time holds
        send_cmd(plain_beat(CMD_TICK, 4'd8));
        send_cmd(plain_beat(CMD_FINISH, 4'd0));
        send_cmd(plain_beat(CMD_FINISH, 4'd0));
        send_cmd(plain_beat(CMD_FINISH, 4'd15));
        // restart with instances still charged
        send_cmd(plain_beat(CMD_START, 4'd1));
        send_cmd(plain_beat(CMD_TICK, 4'd10));
        send_cmd(plain_beat(CMD_FINISH, 4'd7));
        drain();

        // Zero budgets and a thread limit of zero block every dispatch.
        configure(20'd0, 20'd0, 4'd0, 32'hFFFF_FFFF);
        send_cmd(plain_beat(CMD_TICK, 4'd11));
        send_cmd(plain_beat(CMD_FINISH, 4'd3));
        send_cmd(plain_beat(CMD_FINISH, 4'd7));
        send_cmd(plain_beat(CMD_TICK, 4'd12));
        drain();

        // No run time at all: every tick is already past the limit.
        configure(20'd200000, 20'd65535, 4'd1, 32'd0);
        send_cmd(plain_beat(CMD_TICK, 4'd13));
        send_cmd(plain_beat(CMD_START, 4'd14));
        send_cmd(plain_beat(CMD_TICK, 4'd15));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            threads = (r < 10) ? 4'd0 : (r < 35) ? 4'd8 : 4'($urandom_range(1, 7));
            r = $urandom_range(0, 99);
            run = (r < 10) ? 32'd0 : (r < 25) ? 32'hFFFF_FFFF :
                  (r < 80) ? 32'($urandom_range(1, 20)) : $urandom;
            configure(pick_budget(), pick_budget(), threads, run);
            random_phase(PHASE_ITEMS);
            drain();
        end

        if (tracker.mismatches == 0 && tracker.expected_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
